// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the frame projector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IQFP_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("iqfp assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IQFP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("iqfp assertion failed");

`endif

// ----- src/iqfp_pkg.sv -----
// Types, constants and the arctangent table of the frame projector.
package iqfp_pkg;

  localparam int unsigned InWidth  = 256;
  localparam int unsigned OutWidth = 288;

  localparam logic signed [27:0] AngPi    = 28'sd52707179;
  localparam logic signed [16:0] AngLimit = 17'sd25736;

  localparam logic [1:0] AngRoll  = 2'd0;
  localparam logic [1:0] AngPitch = 2'd1;
  localparam logic [1:0] AngYaw   = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_QPROD,
    OP_MATRIX,
    OP_PROJ_RATE,
    OP_PROJ_ACC,
    OP_SQ,
    OP_FILT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] row;
    logic [1:0] col;
    logic [3:0] n;
    logic       part;
    logic       capture;
    logic       start_cordic;
    logic       start_sqrt;
    logic       store_ang;
    logic [1:0] ang_sel;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic cordic_busy;
    logic sqrt_busy;
    logic out_stall;
  } status_t;

  // atan(2^-i) at scale 2^24
  function automatic logic signed [27:0] atan_lut(input logic [4:0] i);
    logic signed [27:0] v;
    case (i)
      5'd0:    v = 28'sd13176795;
      5'd1:    v = 28'sd7778716;
      5'd2:    v = 28'sd4110060;
      5'd3:    v = 28'sd2086331;
      5'd4:    v = 28'sd1047214;
      5'd5:    v = 28'sd524117;
      5'd6:    v = 28'sd262123;
      5'd7:    v = 28'sd131069;
      5'd8:    v = 28'sd65536;
      5'd9:    v = 28'sd32768;
      5'd10:   v = 28'sd16384;
      5'd11:   v = 28'sd8192;
      5'd12:   v = 28'sd4096;
      5'd13:   v = 28'sd2048;
      5'd14:   v = 28'sd1024;
      5'd15:   v = 28'sd512;
      5'd16:   v = 28'sd256;
      5'd17:   v = 28'sd128;
      5'd18:   v = 28'sd64;
      5'd19:   v = 28'sd32;
      5'd20:   v = 28'sd16;
      5'd21:   v = 28'sd8;
      5'd22:   v = 28'sd4;
      5'd23:   v = 28'sd2;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/iqfp_cordic.sv -----
// Iterative vectoring CORDIC computing atan2(y, x) in Q3.13.
module iqfp_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [17:0] y_i,
  input  logic signed [17:0] x_i,
  output logic               busy_o,
  output logic signed [15:0] angle_o
);

  logic               busy_q;
  logic [4:0]         step_q;
  logic signed [35:0] x_q, y_q;
  logic signed [27:0] z_q, base_q;
  logic               zero_q;

  logic signed [18:0] xs, ys;
  logic signed [27:0] base_d;
  logic signed [35:0] dx, dy;
  logic signed [27:0] atan_v, fin;
  logic signed [16:0] ang;

  always_comb begin
    xs     = 19'(x_i);
    ys     = 19'(y_i);
    base_d = '0;
    if (x_i < 0) begin
      xs     = -19'(x_i);
      ys     = -19'(y_i);
      base_d = (y_i >= 0) ? iqfp_pkg::AngPi : -iqfp_pkg::AngPi;
    end
  end

  assign dx     = y_q >>> step_q;
  assign dy     = x_q >>> step_q;
  assign atan_v = iqfp_pkg::atan_lut(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 5'd1;
      if (step_q == 5'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= 36'(xs) <<< 14;
      y_q    <= 36'(ys) <<< 14;
      z_q    <= '0;
      base_q <= base_d;
      zero_q <= (x_i == 0) && (y_i == 0);
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_v;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_v;
      end
    end
  end

  // round the 2^24 angle to Q3.13 and clamp to +-pi
  assign fin = base_q + z_q + 28'sd1024;
  assign ang = fin[27:11];

  always_comb begin
    if (zero_q) begin
      angle_o = '0;
    end else if (ang > iqfp_pkg::AngLimit) begin
      angle_o = 16'(iqfp_pkg::AngLimit);
    end else if (ang < -iqfp_pkg::AngLimit) begin
      angle_o = 16'(-iqfp_pkg::AngLimit);
    end else begin
      angle_o = ang[15:0];
    end
  end

  assign busy_o = busy_q;

endmodule

// ----- src/iqfp_isqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
module iqfp_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] v_i,
  output logic        busy_o,
  output logic [15:0] root_o
);

  logic        busy_q;
  logic [3:0]  k_q;
  logic [31:0] v_q, r_q;
  logic [31:0] bitv;
  logic [32:0] trial;

  assign bitv  = 32'h4000_0000 >> {k_q, 1'b0};
  assign trial = {1'b0, r_q} + {1'b0, bitv};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      k_q    <= '0;
    end else if (busy_q) begin
      k_q <= k_q + 4'd1;
      if (k_q == 4'd15) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= v_i;
      r_q <= '0;
    end else if (busy_q) begin
      if ({1'b0, v_q} >= trial) begin
        v_q <= v_q - trial[31:0];
        r_q <= (r_q >> 1) + bitv;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = r_q[15:0];

endmodule

// ----- src/iqfp_dp.sv -----
// Datapath: shared multiplier, matrix, projections, filters and output register.
module iqfp_dp #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iqfp_pkg::cmd_t                cmd_i,
  output iqfp_pkg::status_t             status_o,
  input  logic [15:0]                   alpha_i,
  input  logic [iqfp_pkg::InWidth-1:0]  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [iqfp_pkg::OutWidth-1:0] out_data_o
);

  logic signed [15:0] q_q     [4];
  logic signed [31:0] rate_q  [3];
  logic signed [31:0] accel_q [3];
  logic signed [31:0] p_q     [9];
  logic signed [16:0] e_q     [3][3];
  logic signed [15:0] ang_q   [3];
  logic signed [31:0] br_q    [3];
  logic signed [31:0] ba_q    [3];
  logic signed [31:0] prev_q  [12];
  logic signed [51:0] acc_q, prod_q;
  logic [31:0]        sq_acc_q, sum_sq_q;
  iqfp_pkg::cmd_t     cmd_q;
  logic               out_valid_q;
  logic [iqfp_pkg::OutWidth-1:0] out_data_q;

  logic signed [33:0] a_op;
  logic signed [17:0] b_op;
  logic signed [31:0] cur;
  logic signed [51:0] sum;
  logic signed [35:0] raw [3][3];
  logic signed [17:0] cy, cx;
  logic signed [15:0] cangle;
  logic               cbusy, sbusy;
  logic [15:0]        root;

  function automatic logic signed [35:0] two(input logic signed [31:0] v);
    return 36'(v) <<< 1;
  endfunction

  function automatic logic signed [15:0] rnd16(input logic signed [35:0] v);
    logic signed [35:0] t;
    logic signed [21:0] s;
    t = v + 36'sd8192;
    s = t[35:14];
    if (s > 22'sd32767) begin
      return 16'sh7fff;
    end else if (s < -22'sd32768) begin
      return 16'sh8000;
    end
    return s[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [37:0] s;
    s = v[51:14];
    if (s > 38'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (s < -38'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    a_op = '0;
    b_op = '0;
    cur  = '0;
    case (cmd_i.n)
      4'd0, 4'd1, 4'd2: cur = 32'(ang_q[cmd_i.n[1:0]]);
      4'd3, 4'd4, 4'd5: cur = br_q[2'(cmd_i.n - 4'd3)];
      4'd6, 4'd7, 4'd8: cur = ba_q[2'(cmd_i.n - 4'd6)];
      4'd9, 4'd10, 4'd11: cur = -32'(e_q[2][2'(cmd_i.n - 4'd9)]);
      default: cur = '0;
    endcase
    case (cmd_i.op)
      iqfp_pkg::OP_QPROD: begin
        case (cmd_i.n)
          4'd0: begin a_op = 34'(q_q[0]); b_op = 18'(q_q[0]); end
          4'd1: begin a_op = 34'(q_q[1]); b_op = 18'(q_q[1]); end
          4'd2: begin a_op = 34'(q_q[2]); b_op = 18'(q_q[2]); end
          4'd3: begin a_op = 34'(q_q[0]); b_op = 18'(q_q[1]); end
          4'd4: begin a_op = 34'(q_q[2]); b_op = 18'(q_q[3]); end
          4'd5: begin a_op = 34'(q_q[0]); b_op = 18'(q_q[2]); end
          4'd6: begin a_op = 34'(q_q[1]); b_op = 18'(q_q[3]); end
          4'd7: begin a_op = 34'(q_q[1]); b_op = 18'(q_q[2]); end
          4'd8: begin a_op = 34'(q_q[0]); b_op = 18'(q_q[3]); end
          default: begin a_op = '0; b_op = '0; end
        endcase
      end
      iqfp_pkg::OP_PROJ_RATE: begin
        a_op = 34'(rate_q[cmd_i.col]);
        b_op = 18'(e_q[cmd_i.row][cmd_i.col]);
      end
      iqfp_pkg::OP_PROJ_ACC: begin
        a_op = -34'(accel_q[cmd_i.col]);
        b_op = 18'(e_q[cmd_i.col][cmd_i.row]);
      end
      iqfp_pkg::OP_SQ: begin
        a_op = 34'(e_q[2][cmd_i.col[0] ? 2'd2 : 2'd1]);
        b_op = 18'(e_q[2][cmd_i.col[0] ? 2'd2 : 2'd1]);
      end
      iqfp_pkg::OP_FILT: begin
        if (!cmd_i.part) begin
          a_op = 34'(prev_q[cmd_i.n]);
          b_op = $signed({2'b00, alpha_i});
        end else begin
          a_op = 34'(cur);
          b_op = $signed(18'(18'd65536 - {2'b00, alpha_i}));
        end
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
    end else begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_op * b_op;
  end

  always_comb begin
    raw[0][0] = 36'sd268435456 - two(p_q[1]) - two(p_q[2]);
    raw[0][1] = two(p_q[3]) - two(p_q[4]);
    raw[0][2] = two(p_q[5]) + two(p_q[6]);
    raw[1][0] = two(p_q[3]) + two(p_q[4]);
    raw[1][1] = 36'sd268435456 - two(p_q[0]) - two(p_q[2]);
    raw[1][2] = two(p_q[7]) - two(p_q[8]);
    raw[2][0] = two(p_q[5]) - two(p_q[6]);
    raw[2][1] = two(p_q[7]) + two(p_q[8]);
    raw[2][2] = 36'sd268435456 - two(p_q[0]) - two(p_q[1]);
  end

  assign sum = acc_q + prod_q;

  // hold the sample on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < 4; i++) begin
        q_q[i] <= in_data_i[16*i +: 16];
      end
      for (int i = 0; i < 3; i++) begin
        rate_q[i]  <= in_data_i[64 + 32*i +: 32];
        accel_q[i] <= in_data_i[160 + 32*i +: 32];
      end
    end
  end

  // use the previous cycle's command and product; angles use the current command
  always_ff @(posedge clk_i) begin
    case (cmd_q.op)
      iqfp_pkg::OP_QPROD: p_q[cmd_q.n] <= prod_q[31:0];
      iqfp_pkg::OP_MATRIX: begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            e_q[i][j] <= (i == 0) ? 17'(rnd16(raw[i][j])) : -17'(rnd16(raw[i][j]));
          end
        end
      end
      iqfp_pkg::OP_PROJ_RATE, iqfp_pkg::OP_PROJ_ACC: begin
        if (cmd_q.col == 2'd0) begin
          acc_q <= prod_q + 52'sd8192;
        end else if (cmd_q.col == 2'd1) begin
          acc_q <= sum;
        end else if (cmd_q.op == iqfp_pkg::OP_PROJ_RATE) begin
          br_q[cmd_q.row] <= sat32(sum);
        end else begin
          ba_q[cmd_q.row] <= sat32(sum);
        end
      end
      iqfp_pkg::OP_SQ: begin
        if (cmd_q.col == 2'd0) begin
          sq_acc_q <= prod_q[31:0];
        end else begin
          sum_sq_q <= sq_acc_q + prod_q[31:0];
        end
      end
      iqfp_pkg::OP_FILT: begin
        if (!cmd_q.part) begin
          acc_q <= prod_q + 52'sd32768;
        end
      end
      default: ;
    endcase
    if (cmd_i.store_ang) begin
      ang_q[cmd_i.ang_sel] <= cangle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 12; i++) begin
        prev_q[i] <= '0;
      end
    end else if (cmd_q.op == iqfp_pkg::OP_FILT && cmd_q.part) begin
      prev_q[cmd_q.n] <= sum[47:16];
    end
  end

  always_comb begin
    case (cmd_i.ang_sel)
      iqfp_pkg::AngRoll: begin
        cy = 18'(e_q[2][1]);
        cx = 18'(e_q[2][2]);
      end
      iqfp_pkg::AngPitch: begin
        cy = -18'(e_q[2][0]);
        cx = $signed({2'b00, root});
      end
      default: begin
        cy = 18'(e_q[1][0]);
        cx = 18'(e_q[0][0]);
      end
    endcase
  end

  iqfp_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start_cordic),
    .y_i    (cy),
    .x_i    (cx),
    .busy_o (cbusy),
    .angle_o(cangle)
  );

  iqfp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start_sqrt),
    .v_i    (sum_sq_q),
    .busy_o (sbusy),
    .root_o (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {prev_q[11][15:0], prev_q[10][15:0], prev_q[9][15:0],
                     prev_q[8], prev_q[7], prev_q[6],
                     prev_q[5], prev_q[4], prev_q[3],
                     prev_q[2][15:0], prev_q[1][15:0], prev_q[0][15:0]};
    end
  end

  assign status_o.cordic_busy = cbusy;
  assign status_o.sqrt_busy   = sbusy;
  assign status_o.out_stall   = out_valid_q && !out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign out_data_o           = out_data_q;

endmodule

// ----- src/iqfp_ctrl.sv -----
// Controller: sequences the multiplier, root, CORDIC and filter steps per sample.
module iqfp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  iqfp_pkg::status_t status_i,
  output iqfp_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MAT, S_MATX, S_MATW, S_PROJ, S_SQ, S_SYNC,
    S_ROOT, S_WROOT, S_PITCH, S_WPITCH, S_YAW, S_WYAW,
    S_FILT, S_FLUSH, S_OUT
  } state_e;

  state_e     state_q;
  logic [4:0] cnt_q;
  logic [1:0] row_q, col_q;
  logic       kind_q;
  logic       units_idle;

  assign units_idle = !status_i.cordic_busy && !status_i.sqrt_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      kind_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) begin
            state_q <= S_MAT;
          end
        end
        S_MAT: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd8) begin
            state_q <= S_MATX;
          end
        end
        S_MATX: state_q <= S_MATW;
        S_MATW: begin
          row_q   <= '0;
          col_q   <= '0;
          kind_q  <= 1'b0;
          state_q <= S_PROJ;
        end
        S_PROJ: begin
          if (col_q == 2'd2) begin
            col_q <= '0;
            if (row_q == 2'd2) begin
              row_q <= '0;
              if (kind_q) begin
                state_q <= S_SQ;
              end
              kind_q <= 1'b1;
            end else begin
              row_q <= row_q + 2'd1;
            end
          end else begin
            col_q <= col_q + 2'd1;
          end
        end
        S_SQ: begin
          col_q <= col_q + 2'd1;
          if (col_q == 2'd1) begin
            state_q <= S_SYNC;
          end
        end
        S_SYNC:  state_q <= S_ROOT;
        S_ROOT:  state_q <= S_WROOT;
        S_WROOT: if (units_idle) state_q <= S_PITCH;
        S_PITCH: state_q <= S_WPITCH;
        S_WPITCH: if (units_idle) state_q <= S_YAW;
        S_YAW:   state_q <= S_WYAW;
        S_WYAW: begin
          cnt_q <= '0;
          if (units_idle) begin
            state_q <= S_FILT;
          end
        end
        S_FILT: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd23) begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: state_q <= S_OUT;
        S_OUT:   if (!status_i.out_stall) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o     = '0;
    cmd_o.row = row_q;
    cmd_o.col = col_q;
    case (state_q)
      S_IDLE:  cmd_o.capture = in_valid_i;
      S_MAT: begin
        cmd_o.op = iqfp_pkg::OP_QPROD;
        cmd_o.n  = cnt_q[3:0];
      end
      S_MATX:  cmd_o.op = iqfp_pkg::OP_MATRIX;
      S_PROJ:  cmd_o.op = kind_q ? iqfp_pkg::OP_PROJ_ACC : iqfp_pkg::OP_PROJ_RATE;
      S_SQ:    cmd_o.op = iqfp_pkg::OP_SQ;
      S_ROOT: begin
        cmd_o.start_cordic = 1'b1;
        cmd_o.start_sqrt   = 1'b1;
        cmd_o.ang_sel      = iqfp_pkg::AngRoll;
      end
      S_WROOT: begin
        cmd_o.ang_sel   = iqfp_pkg::AngRoll;
        cmd_o.store_ang = units_idle;
      end
      S_PITCH: begin
        cmd_o.start_cordic = 1'b1;
        cmd_o.ang_sel      = iqfp_pkg::AngPitch;
      end
      S_WPITCH: begin
        cmd_o.ang_sel   = iqfp_pkg::AngPitch;
        cmd_o.store_ang = units_idle;
      end
      S_YAW: begin
        cmd_o.start_cordic = 1'b1;
        cmd_o.ang_sel      = iqfp_pkg::AngYaw;
      end
      S_WYAW: begin
        cmd_o.ang_sel   = iqfp_pkg::AngYaw;
        cmd_o.store_ang = units_idle;
      end
      S_FILT: begin
        cmd_o.op   = iqfp_pkg::OP_FILT;
        cmd_o.n    = cnt_q[4:1];
        cmd_o.part = cnt_q[0];
      end
      S_OUT:   cmd_o.load_out = !status_i.out_stall;
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ----- src/imu_quaternion_frame_projector_unit.sv -----
// Top level of the IMU quaternion frame projector.
// Takes one IMU sample per transaction and returns one filtered result: roll,
// pitch and yaw, the projected rate and acceleration, and the gravity vector.
// One sample is processed at a time. The next sample can be taken once the
// result has been loaded into the output register. The square root overlaps the
// roll angle; below 16 CORDIC steps the square root sets the roll wait instead.
// The time is set by the single shared 34x18 multiplier doing 53 products and
// the one iterative CORDIC unit evaluating the three angles in turn. A finished
// result waits in the output register and is presented until taken; a stalled
// result holds the controller and so the input. alpha is to be written over the
// APB port only while the block is idle; the block itself does not enforce this.
module imu_quaternion_frame_projector_unit #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // quat_x, quat_y, quat_z, quat_w, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z
  input  logic [iqfp_pkg::InWidth-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // roll, pitch, yaw, body_rate_x/y/z, body_accel_x/y/z, grav_x, grav_y, grav_z
  output logic [iqfp_pkg::OutWidth-1:0] m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  `include "assert_macros.svh"

  iqfp_pkg::cmd_t    cmd;
  iqfp_pkg::status_t status;
  logic [15:0]       alpha_q;
  logic              hit;

  assign hit    = !paddr[2];
  assign pready = 1'b1;
  assign prdata = hit ? {16'b0, alpha_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
    end else if (psel && penable && pwrite && hit) begin
      alpha_q <= pwdata[15:0];
    end
  end

  iqfp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  iqfp_dp #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .alpha_i    (alpha_q),
    .in_data_i  (s_axis_tdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

  `IQFP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `IQFP_ASSERT_IMPL(a_no_cordic_restart, status.cordic_busy, !cmd.start_cordic)
  `IQFP_ASSERT_IMPL(a_load_into_free_slot, cmd.load_out, !m_axis_tvalid || m_axis_tready)
  `IQFP_ASSERT_IMPL(a_no_load_while_idle, s_axis_tready, !cmd.load_out && !cmd.store_ang)

endmodule

// ----- tb/sv/imu_quaternion_frame_projector_unit_checker.sv -----
// Checker for the frame projector: predicts each result and compares it with the output stream.
module imu_quaternion_frame_projector_unit_checker #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter logic [2:0]  ALPHA_ADDR   = 3'd0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // quat_x, quat_y, quat_z, quat_w, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z
  input  logic [iqfp_pkg::InWidth-1:0]  s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // roll, pitch, yaw, body_rate_x/y/z, body_accel_x/y/z, grav_x, grav_y, grav_z
  input  logic [iqfp_pkg::OutWidth-1:0] m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HalfTurn   = 64'sd52707179;
  localparam longint AngleClamp = 64'sd25736;
  localparam longint MatOne     = 64'sd1 << 28;

  localparam longint ArctanTab[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };
  localparam int FieldOfs[12] = '{0, 16, 32, 48, 80, 112, 144, 176, 208, 240, 256, 272};
  localparam int FieldWid[12] = '{16, 16, 16, 32, 32, 32, 32, 32, 32, 16, 16, 16};
  localparam string FieldName[12] = '{"roll", "pitch", "yaw", "body_rate_x", "body_rate_y",
    "body_rate_z", "body_accel_x", "body_accel_y", "body_accel_z", "grav_x", "grav_y",
    "grav_z"};

  logic [15:0]                   alpha;
  longint                        filt_state[12];
  logic [iqfp_pkg::OutWidth-1:0] pose_due_q[$];

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint arctan2(longint y, longint x);
    longint base, z, dx, dy;
    base = 0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? HalfTurn : -HalfTurn;
      x = -x;
      y = -y;
    end
    x = x * 16384;
    y = y * 16384;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + ArctanTab[i];
      end else begin
        x = x - dx; y = y + dy; z = z - ArctanTab[i];
      end
    end
    return sat((base + z + 1024) >>> 11, -AngleClamp, AngleClamp);
  endfunction

  // Advance the filter state by one sample and return the packed pose.
  function automatic logic [iqfp_pkg::OutWidth-1:0] project_pose(
      logic [iqfp_pkg::InWidth-1:0] d);
    longint qx, qy, qz, qw, sr, sa, a;
    longint rate[3], acc[3], raw[3][3], e[3][3], cur[12];
    logic [iqfp_pkg::OutWidth-1:0] res;
    qx = longint'($signed(d[15:0]));
    qy = longint'($signed(d[31:16]));
    qz = longint'($signed(d[47:32]));
    qw = longint'($signed(d[63:48]));
    for (int i = 0; i < 3; i++) begin
      rate[i] = longint'($signed(d[64+32*i +: 32]));
      acc[i]  = -longint'($signed(d[160+32*i +: 32]));
    end
    raw[0][0] = MatOne - 2*qy*qy - 2*qz*qz;
    raw[0][1] = 2*qx*qy - 2*qz*qw;
    raw[0][2] = 2*qx*qz + 2*qy*qw;
    raw[1][0] = 2*qx*qy + 2*qz*qw;
    raw[1][1] = MatOne - 2*qx*qx - 2*qz*qz;
    raw[1][2] = 2*qy*qz - 2*qx*qw;
    raw[2][0] = 2*qx*qz - 2*qy*qw;
    raw[2][1] = 2*qy*qz + 2*qx*qw;
    raw[2][2] = MatOne - 2*qx*qx - 2*qy*qy;
    // round and saturate each entry, then apply the frame fix: negate rows 1 and 2
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        e[i][j] = sat((raw[i][j] + 8192) >>> 14, -32768, 32767);
        if (i != 0) e[i][j] = -e[i][j];
      end
    cur[0] = arctan2(e[2][1], e[2][2]);
    cur[1] = arctan2(-e[2][0], int_sqrt(longint'(e[2][1]*e[2][1] + e[2][2]*e[2][2])));
    cur[2] = arctan2(e[1][0], e[0][0]);
    for (int i = 0; i < 3; i++) begin
      sr = 0;
      sa = 0;
      for (int j = 0; j < 3; j++) begin
        sr = sr + e[i][j] * rate[j];
        sa = sa + e[j][i] * acc[j];
      end
      cur[3+i] = sat((sr + 8192) >>> 14, -64'sd2147483648, 64'sd2147483647);
      cur[6+i] = sat((sa + 8192) >>> 14, -64'sd2147483648, 64'sd2147483647);
      cur[9+i] = -e[2][i];
    end
    a = longint'(alpha);
    res = '0;
    for (int k = 0; k < 12; k++) begin
      filt_state[k] = (filt_state[k] * a + cur[k] * (65536 - a) + 32768) >>> 16;
      for (int b = 0; b < FieldWid[k]; b++) res[FieldOfs[k] + b] = filt_state[k][b];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [iqfp_pkg::OutWidth-1:0] want;
    longint got_v, want_v;
    if (!rst_ni) begin
      alpha <= '0;
      for (int k = 0; k < 12; k++) filt_state[k] = 0;
      pose_due_q.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pose_due_q.size() == 0) begin
          $error("result transaction with no sample pending: %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = pose_due_q.pop_front();
          checked_o++;
          for (int k = 0; k < 12; k++) begin
            got_v = 0;
            want_v = 0;
            for (int b = 0; b < FieldWid[k]; b++) begin
              got_v[b]  = m_axis_tdata[FieldOfs[k] + b];
              want_v[b] = want[FieldOfs[k] + b];
            end
            if (got_v != want_v) begin
              $error("%s mismatch: expected %0h, actual %0h", FieldName[k], want_v, got_v);
              fail_count_o++;
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) pose_due_q.push_back(project_pose(s_axis_tdata));
      if (psel && penable && pwrite && pready && paddr == ALPHA_ADDR) alpha <= pwdata[15:0];
    end
    pending_o = pose_due_q.size();
  end

endmodule

// ----- tb/sv/imu_quaternion_frame_projector_unit_test.sv -----
// Stimulus and verdict for the IMU quaternion frame projector.
module imu_quaternion_frame_projector_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] AlphaAddr  = 3'd0;
  localparam logic [2:0] UnusedAddr = 3'd4;
  localparam int         PhaseItems = 250;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // quat_x, quat_y, quat_z, quat_w, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z
  logic [iqfp_pkg::InWidth-1:0]  s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  // roll, pitch, yaw, body_rate_x/y/z, body_accel_x/y/z, grav_x, grav_y, grav_z
  logic [iqfp_pkg::OutWidth-1:0] m_axis_tdata;
  logic                          psel, penable, pwrite, pready;
  logic [2:0]                    paddr;
  logic [31:0]                   pwdata, prdata;
  int                            fail_count, pending, checked;
  int                            ready_hold;
  int                            samples_sent;
  logic [15:0]                   alpha_list[6];

  imu_quaternion_frame_projector_unit u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  imu_quaternion_frame_projector_unit_checker #(.ALPHA_ADDR(AlphaAddr)) u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver backpressure: runs of ready, short stalls and a few long stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    int r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        m_axis_tready <= 1'b1;
        ready_hold <= $urandom_range(1, 40);
      end else if (r < 88) begin
        m_axis_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold <= $urandom_range(10, 150);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 200);
  endfunction

  function automatic logic [31:0] pick_vec_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    if (r < 80) return $urandom;
    if (r < 90) return 32'h8000_0000;
    return 32'h7fff_ffff;
  endfunction

  function automatic logic [15:0] pick_quat_word();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [iqfp_pkg::InWidth-1:0] make_sample(
      logic [15:0] qx, logic [15:0] qy, logic [15:0] qz, logic [15:0] qw,
      logic [31:0] rv, logic [31:0] av);
    return {av, av, av, rv, rv, rv, qw, qz, qy, qx};
  endfunction

  function automatic logic [iqfp_pkg::InWidth-1:0] random_sample();
    logic [iqfp_pkg::InWidth-1:0] d;
    for (int i = 0; i < 4; i++) d[16*i +: 16] = pick_quat_word();
    for (int i = 0; i < 6; i++) d[64 + 32*i +: 32] = pick_vec_word();
    // sometimes zero one quaternion component so the angles land on their edges
    if ($urandom_range(0, 9) == 0) d[16*$urandom_range(0, 3) +: 16] = 16'd0;
    return d;
  endfunction

  // Hold the sample until its transaction completes, then leave a gap if one is asked for.
  task automatic send_sample(logic [iqfp_pkg::InWidth-1:0] d, int gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    samples_sent++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    samples_sent = 0;
    alpha_list = '{16'd0, 16'hffff, 16'h8000, 16'h0001, 16'h4000, 16'hc000};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity (x negative, y zero for roll), zero quaternion,
    // half turns, quarter turns, saturating quaternions, extreme rates and accelerations.
    apb_write(AlphaAddr, 32'd0);
    send_sample(make_sample(16'd0, 16'd0, 16'd0, 16'd16384, 32'h0001_0000, 32'h0009_cccd), 0);
    send_sample(make_sample(16'd0, 16'd0, 16'd0, 16'd0, 32'h7fff_ffff, 32'h8000_0000), 1);
    send_sample(make_sample(16'd16384, 16'd0, 16'd0, 16'd0, 32'h8000_0000, 32'h7fff_ffff), 0);
    send_sample(make_sample(16'd0, 16'd16384, 16'd0, 16'd0, 32'h7fff_ffff, 32'h7fff_ffff), 0);
    send_sample(make_sample(16'd0, 16'd0, 16'd16384, 16'd0, 32'h8000_0000, 32'h8000_0000), 2);
    send_sample(make_sample(16'hc000, 16'hc000, 16'hc000, 16'hc000, 32'hffff_ffff, 32'd0), 0);
    send_sample(make_sample(16'd16384, 16'd16384, 16'd16384, 16'd16384, 32'd1, 32'hffff_ffff), 0);
    send_sample(make_sample(16'hc000, 16'd16384, 16'hc000, 16'd16384, 32'h5555_5555,
                            32'haaaa_aaaa), 0);
    send_sample(make_sample(16'd11585, 16'd0, 16'd0, 16'd11585, 32'h0000_8000, 32'hffff_8000), 0);
    send_sample(make_sample(16'd0, 16'd11585, 16'd0, 16'd11585, 32'h0123_4567, 32'hfedc_ba98), 0);
    send_sample(make_sample(16'd0, 16'd0, 16'd11585, 16'hd2bf, 32'h8000_0000, 32'h0000_0001), 0);
    send_sample(make_sample(16'd0, 16'd0, 16'd0, 16'hc000, 32'd0, 32'd0), 0);
    send_sample(make_sample(16'd8192, 16'd8192, 16'd8192, 16'd8192, 32'h7fff_ffff,
                            32'h7fff_ffff), 0);
    drain_results();
    apb_write(UnusedAddr, 32'hffff_ffff);
    apb_write(AlphaAddr, 32'hffff_ffff);
    for (int i = 0; i < 6; i++) send_sample(random_sample(), pick_gap());
    drain_results();

    foreach (alpha_list[p]) begin
      apb_write(AlphaAddr, (p == 3) ? {$urandom} : {16'hdead, alpha_list[p]});
      for (int i = 0; i < PhaseItems - 50 * (p % 2); i++) begin
        send_sample(random_sample(), (p == 2) ? 0 : pick_gap());
        if (i == PhaseItems / 2) drain_results();
      end
      drain_results();
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d IMU samples over %0d alpha settings; %0d filtered poses compared.",
             samples_sent, 8, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
